@@ hw/rtl/shwc_pkg.sv @@
// Shared types and constants for the section header walk cache.
package shwc_pkg;

  localparam int unsigned ENTRIES   = 16;
  localparam int unsigned TAG_BITS  = 36;
  localparam int unsigned SECTION_W = 36;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_FILL   = 1'b1;

  // priority chain running from entry 0 upwards
  typedef struct packed {
    logic free_seen;
    logic hit_seen;
  } chain_t;

  // selected-entry gather chain (rank travels alongside)
  typedef struct packed {
    logic any;
    logic valid;
    logic pg_small;
    logic pg_large;
  } gath_t;

  // update broadcast to every cell
  typedef struct packed {
    logic en;
    logic fill;
    logic pg_small;
    logic pg_large;
    logic any_hit;
    logic any_free;
    logic sel_any;
    logic sel_valid;
  } ctl_t;

endpackage

@@ hw/rtl/shwc_cell.sv @@
// One cache entry: tag, flags, valid bit and recency rank, with chain links.
module shwc_cell #(
  parameter int unsigned ENTRIES  = shwc_pkg::ENTRIES,
  parameter int unsigned TAG_BITS = shwc_pkg::TAG_BITS,
  localparam int unsigned RankW   = $clog2(ENTRIES)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmp_en_i,
  input  logic [TAG_BITS-1:0]   cmp_tag_i,
  input  logic [TAG_BITS-1:0]   wr_tag_i,
  input  shwc_pkg::ctl_t        ctl_i,
  input  logic [RankW-1:0]      sel_rank_i,
  input  shwc_pkg::chain_t      chain_i,
  output shwc_pkg::chain_t      chain_o,
  input  shwc_pkg::gath_t       gath_i,
  output shwc_pkg::gath_t       gath_o,
  input  logic [RankW-1:0]      rank_i,
  output logic [RankW-1:0]      rank_o
);

  logic                valid_q;
  logic [RankW-1:0]    rank_q;
  logic                match_q;
  logic [TAG_BITS-1:0] tag_q;
  logic                small_q;
  logic                large_q;
  logic                free;
  logic                lru;
  logic                sel;
  logic                age;

  assign free = !valid_q;
  assign lru  = valid_q && (rank_q == RankW'(ENTRIES - 1));

  assign sel = ctl_i.any_hit ? match_q
             : (ctl_i.fill && (ctl_i.any_free ? (free && !chain_i.free_seen) : lru));

  assign age = valid_q && ctl_i.sel_any &&
               (!ctl_i.sel_valid || (rank_q < sel_rank_i));

  assign chain_o.free_seen = chain_i.free_seen | free;
  assign chain_o.hit_seen  = chain_i.hit_seen | match_q;

  assign gath_o.any      = gath_i.any | sel;
  assign gath_o.valid    = gath_i.valid | (sel & valid_q);
  assign gath_o.pg_small = gath_i.pg_small | (sel & small_q);
  assign gath_o.pg_large = gath_i.pg_large | (sel & large_q);
  assign rank_o          = rank_i | (sel ? rank_q : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
      match_q <= 1'b0;
    end else begin
      if (cmp_en_i) begin
        match_q <= valid_q && (tag_q == cmp_tag_i);
      end
      if (ctl_i.en) begin
        if (sel) begin
          valid_q <= 1'b1;
          rank_q  <= '0;
        end else if (age) begin
          rank_q  <= rank_q + RankW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en && sel && ctl_i.fill) begin
      tag_q   <= wr_tag_i;
      small_q <= ctl_i.pg_small;
      large_q <= ctl_i.pg_large;
    end
  end

endmodule

@@ hw/rtl/section_header_walk_cache_top.sv @@
// Section header walk cache: top level with control and the row of entry cells.
//
// Input channel (in_valid_i/in_ready_o) carries one word: op, section tag and,
// for a fill, the small and large page flags. Output channel
// (out_valid_o/out_ready_i) returns one word per input: found and, for a
// lookup hit, the stored flags.
// An accepted word is compared against every entry at the accepting edge; the
// update state then resolves hit, free slot or LRU victim along the cell row,
// updates tags, flags and ranks, and loads the output register. No new word is
// taken while the update state is busy with the last one (in_ready_o low).
// The output register decouples the sides: a new word is accepted while a
// result waits. If the receiver stalls with a result still held, the update
// cycle waits until the output register frees up.
// Reset empties the cache (all entries invalid) and drops any pending result.
module section_header_walk_cache_top #(
  parameter int unsigned ENTRIES  = shwc_pkg::ENTRIES,
  parameter int unsigned TAG_BITS = shwc_pkg::TAG_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           op_i,
  input  logic [shwc_pkg::SECTION_W-1:0] section_i,
  input  logic                           small_pages_i,
  input  logic                           large_pages_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           found_o,
  output logic                           found_small_o,
  output logic                           found_large_o
);

  localparam int unsigned RankW = $clog2(ENTRIES);
  localparam int unsigned ExtW  = shwc_pkg::SECTION_W + TAG_BITS;

  typedef enum logic {
    ST_IDLE,
    ST_UPD
  } state_e;

  state_e              state_q;
  logic                op_q;
  logic                small_q;
  logic                large_q;
  logic [TAG_BITS-1:0] tag_q;
  logic                out_valid_q;
  logic                found_q;
  logic                found_small_q;
  logic                found_large_q;

  logic [ExtW-1:0]     section_ext;
  logic [TAG_BITS-1:0] in_tag;
  logic                accept;
  logic                fire;
  logic                is_fill;

  shwc_pkg::chain_t    chain [ENTRIES+1];
  shwc_pkg::gath_t     gath  [ENTRIES+1];
  logic [RankW-1:0]    rank  [ENTRIES+1];
  shwc_pkg::ctl_t      ctl;

  assign section_ext = {{TAG_BITS{1'b0}}, section_i};
  assign in_tag      = section_ext[TAG_BITS-1:0];
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign fire        = (state_q == ST_UPD) && (!out_valid_q || out_ready_i);
  assign is_fill     = (op_q == shwc_pkg::OP_FILL);

  assign chain[0] = '0;
  assign gath[0]  = '0;
  assign rank[0]  = '0;

  assign ctl.en        = fire;
  assign ctl.fill      = is_fill;
  assign ctl.pg_small  = small_q;
  assign ctl.pg_large  = large_q;
  assign ctl.any_hit   = chain[ENTRIES].hit_seen;
  assign ctl.any_free  = chain[ENTRIES].free_seen;
  assign ctl.sel_any   = gath[ENTRIES].any;
  assign ctl.sel_valid = gath[ENTRIES].valid;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    shwc_cell #(
      .ENTRIES  (ENTRIES),
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmp_en_i   (accept),
      .cmp_tag_i  (in_tag),
      .wr_tag_i   (tag_q),
      .ctl_i      (ctl),
      .sel_rank_i (rank[ENTRIES]),
      .chain_i    (chain[g]),
      .chain_o    (chain[g+1]),
      .gath_i     (gath[g]),
      .gath_o     (gath[g+1]),
      .rank_i     (rank[g]),
      .rank_o     (rank[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      found_q       <= 1'b0;
      found_small_q <= 1'b0;
      found_large_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
          if (accept) begin
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (fire) begin
            out_valid_q   <= 1'b1;
            found_q       <= ctl.any_hit;
            found_small_q <= !is_fill && ctl.any_hit && gath[ENTRIES].pg_small;
            found_large_q <= !is_fill && ctl.any_hit && gath[ENTRIES].pg_large;
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_i;
      tag_q   <= in_tag;
      small_q <= small_pages_i;
      large_q <= large_pages_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign found_small_o = found_small_q;
  assign found_large_o = found_large_q;

endmodule

@@ test/section_header_walk_cache_top_tb.sv @@
// Testbench for the section header walk cache: directed rows, random traffic, LRU predictor.
module section_header_walk_cache_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_WORDS = 1900;
  localparam int unsigned POOL_SIZE    = 40;
  localparam int unsigned LONG_HOLD    = 150;
  localparam int unsigned SEC_W        = shwc_pkg::SECTION_W;
  localparam int unsigned NUM_LINES    = shwc_pkg::ENTRIES;
  localparam logic [SEC_W-1:0] TAG_MASK =
    SEC_W'((65'd1 << shwc_pkg::TAG_BITS) - 65'd1);
  localparam logic [SEC_W-1:0] SEC_MAX  = '1;

  typedef struct packed {
    logic found;
    logic pg_small;
    logic pg_large;
  } walk_result_t;

  typedef struct {
    logic             op;
    logic [SEC_W-1:0] section;
    logic             sp;
    logic             lp;
    logic             checked;
    walk_result_t     res;
  } directed_row_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             in_valid_i    = 1'b0;
  logic             in_ready_o;
  logic             op_i          = shwc_pkg::OP_LOOKUP;
  logic [SEC_W-1:0] section_i     = '0;
  logic             small_pages_i = 1'b0;
  logic             large_pages_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i   = 1'b0;
  logic             found_o;
  logic             found_small_o;
  logic             found_large_o;

  // typed expectation travelling with the word on offer
  logic             row_checked   = 1'b0;
  walk_result_t     row_result    = '0;

  // shadow of the cache contents
  logic             line_valid [NUM_LINES];
  logic [SEC_W-1:0] line_tag   [NUM_LINES];
  logic             line_small [NUM_LINES];
  logic             line_large [NUM_LINES];
  int unsigned      line_rank  [NUM_LINES];

  walk_result_t     pending_q [$];
  directed_row_t    directed_rows [$];
  logic [SEC_W-1:0] tag_pool [POOL_SIZE];
  int unsigned      mismatch_count = 0;
  int unsigned      burst_left     = 0;
  bit               hold_req       = 1'b0;

  section_header_walk_cache_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .section_i     (section_i),
    .small_pages_i (small_pages_i),
    .large_pages_i (large_pages_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .found_small_o (found_small_o),
    .found_large_o (found_large_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic void add_row(input directed_row_t row);
    directed_rows = {directed_rows, row};
  endfunction

  function automatic void make_newest(input int e);
    int unsigned old_rank;
    old_rank = line_valid[e] ? line_rank[e] : NUM_LINES;
    for (int i = 0; i < NUM_LINES; i++) begin
      if (i != e && line_valid[i] && line_rank[i] < old_rank) begin
        line_rank[i]++;
      end
    end
    line_rank[e] = 0;
  endfunction

  function automatic walk_result_t predict_walk(input logic op, input logic [SEC_W-1:0] sec,
                                                input logic sp, input logic lp);
    logic [SEC_W-1:0] tag;
    int               hit;
    int               victim;
    walk_result_t     res;
    tag    = sec & TAG_MASK;
    hit    = -1;
    victim = -1;
    res    = '0;
    for (int i = 0; i < NUM_LINES; i++) begin
      if (hit < 0 && line_valid[i] && line_tag[i] == tag) begin
        hit = i;
      end
    end
    if (op == shwc_pkg::OP_LOOKUP) begin
      if (hit >= 0) begin
        make_newest(hit);
        res.found    = 1'b1;
        res.pg_small = line_small[hit];
        res.pg_large = line_large[hit];
      end
    end else if (hit >= 0) begin
      line_small[hit] = sp;
      line_large[hit] = lp;
      make_newest(hit);
      res.found = 1'b1;
    end else begin
      for (int i = 0; i < NUM_LINES; i++) begin
        if (victim < 0 && !line_valid[i]) begin
          victim = i;
        end
      end
      if (victim < 0) begin
        victim = 0;
        for (int i = 1; i < NUM_LINES; i++) begin
          if (line_rank[i] > line_rank[victim]) begin
            victim = i;
          end
        end
      end
      make_newest(victim);
      line_tag[victim]   = tag;
      line_small[victim] = sp;
      line_large[victim] = lp;
      line_valid[victim] = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk_i) begin : watch
    walk_result_t predicted;
    walk_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predicted = predict_walk(op_i, section_i, small_pages_i, large_pages_i);
        pending_q = {pending_q, (row_checked ? row_result : predicted)};
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_q.size() == 0) begin
          report_mismatch("result word with nothing outstanding");
        end else begin
          want = pending_q.pop_front();
          if (found_o !== want.found)
            report_mismatch($sformatf("found %b, want %b", found_o, want.found));
          if (found_small_o !== want.pg_small)
            report_mismatch($sformatf("found_small %b, want %b", found_small_o, want.pg_small));
          if (found_large_o !== want.pg_large)
            report_mismatch($sformatf("found_large %b, want %b", found_large_o, want.pg_large));
        end
      end
    end
  end

  // receiver: shifting stall patterns, plus one long hold-off on request
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    int unsigned tick;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 120);
      repeat (span) begin
        @(posedge clk_i);
        tick++;
        if (hold_req) begin
          hold_req = 1'b0;
          out_ready_i <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk_i);
        end
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 1) == 1);
          2: out_ready_i <= ($urandom_range(0, 4) == 0);
          default: out_ready_i <= (tick % 3 == 0);
        endcase
      end
    end
  end

  task automatic send_word(input logic op, input logic [SEC_W-1:0] sec, input logic sp,
                           input logic lp, input logic checked, input walk_result_t res);
    in_valid_i    <= 1'b1;
    op_i          <= op;
    section_i     <= sec;
    small_pages_i <= sp;
    large_pages_i <= lp;
    row_checked   <= checked;
    row_result    <= res;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic idle_between();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [SEC_W-1:0] random_section();
    return {4'($urandom), 32'($urandom)};
  endfunction

  initial begin : stimulus
    logic             op;
    logic [SEC_W-1:0] sec;
    int unsigned      pool_span;
    for (int i = 0; i < NUM_LINES; i++) begin
      line_valid[i] = 1'b0;
      line_tag[i]   = '0;
      line_small[i] = 1'b0;
      line_large[i] = 1'b0;
      line_rank[i]  = 0;
    end

    // cold misses, first fills, flag readback, update in place
    add_row('{shwc_pkg::OP_LOOKUP, '0,      1'b1, 1'b1, 1'b1, 3'b000});
    add_row('{shwc_pkg::OP_LOOKUP, SEC_MAX, 1'b0, 1'b0, 1'b1, 3'b000});
    add_row('{shwc_pkg::OP_FILL,   '0,      1'b1, 1'b0, 1'b1, 3'b000});
    add_row('{shwc_pkg::OP_FILL,   SEC_MAX, 1'b0, 1'b1, 1'b1, 3'b000});
    add_row('{shwc_pkg::OP_LOOKUP, '0,      1'b0, 1'b1, 1'b1, 3'b110});
    add_row('{shwc_pkg::OP_LOOKUP, SEC_MAX, 1'b1, 1'b0, 1'b1, 3'b101});
    add_row('{shwc_pkg::OP_FILL,   '0,      1'b1, 1'b1, 1'b1, 3'b100});
    add_row('{shwc_pkg::OP_LOOKUP, '0,      1'b0, 1'b0, 1'b1, 3'b111});
    add_row('{shwc_pkg::OP_FILL,   '0,      1'b0, 1'b0, 1'b1, 3'b100});
    // fill the rest of the cache; all-ones becomes least recently used
    for (int k = 0; k < NUM_LINES - 2; k++) begin
      add_row('{shwc_pkg::OP_FILL, SEC_W'(1) << k, k[0], k[1], 1'b0, 3'b000});
    end
    // full cache: new tag evicts all-ones, zero stays
    add_row('{shwc_pkg::OP_FILL,   36'h5_a5a5_a5a5, 1'b1, 1'b1, 1'b1, 3'b000});
    add_row('{shwc_pkg::OP_LOOKUP, SEC_MAX,         1'b0, 1'b0, 1'b1, 3'b000});
    add_row('{shwc_pkg::OP_LOOKUP, '0,              1'b0, 1'b0, 1'b1, 3'b100});

    for (int i = 0; i < POOL_SIZE; i++) begin
      tag_pool[i] = random_section();
    end
    tag_pool[0] = '0;
    tag_pool[1] = SEC_MAX;
    pool_span   = 12;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].op, directed_rows[i].section, directed_rows[i].sp,
                directed_rows[i].lp, directed_rows[i].checked, directed_rows[i].res);
      idle_between();
    end
    wait_drained();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 300) begin
        // long receiver hold-off with the sender pushing hard
        hold_req   = 1'b1;
        burst_left = 60;
      end
      if (n % 450 == 449) begin
        wait_drained();
      end
      if (n % 150 == 0) begin
        pool_span = $urandom_range(4, POOL_SIZE);
      end
      if ($urandom_range(0, 49) == 0) begin
        tag_pool[$urandom_range(2, POOL_SIZE - 1)] = random_section();
      end
      op  = 1'($urandom_range(0, 1));
      sec = ($urandom_range(0, 9) < 8) ? tag_pool[$urandom_range(0, pool_span - 1)]
                                       : random_section();
      send_word(op, sec, 1'($urandom), 1'($urandom), 1'b0, '0);
      idle_between();
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (pending_q.size() != 0) begin
      report_mismatch("results still outstanding at the end");
    end
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ section_header_walk_cache_top.f @@
hw/rtl/shwc_pkg.sv
hw/rtl/shwc_cell.sv
hw/rtl/section_header_walk_cache_top.sv
test/section_header_walk_cache_top_tb.sv
